// ===== rtl/rmth_pkg.sv =====
package rmth_pkg;

    localparam int HEAP_DEPTH  = 512;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_BITS   = $clog2(HEAP_DEPTH);
    localparam int SIZE_BITS   = $clog2(HEAP_DEPTH + 1);
    localparam int COUNT_BITS  = SIZE_BITS + 1;
    localparam int MED_BITS    = SAMPLE_BITS + 1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic                          operation;
        logic signed [SAMPLE_BITS-1:0] sample;
    } rmth_in_t;

    typedef struct packed {
        logic signed [MED_BITS-1:0] median_doubled;
        logic [9:0]                 sample_count;
        logic                       rejected;
    } rmth_out_t;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_LOAD,
        DP_CLEAR,
        DP_PUSH,
        DP_POP,
        DP_MEDIAN
    } rmth_op_t;

    typedef struct packed {
        rmth_op_t op;
        logic     heap_sel;
        logic     use_moved;
    } rmth_cmd_t;

    typedef struct packed {
        logic                 done;
        logic                 full;
        logic [1:0]           count_class;
        logic                 goes_upper;
        logic                 lower_heavy;
        logic                 upper_heavy;
    } rmth_status_t;

endpackage

// ===== rtl/rmth_heap.sv =====
module rmth_heap (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   is_max,
    input  logic                                   clear,
    input  logic                                   push,
    input  logic                                   pop,
    input  logic signed [rmth_pkg::SAMPLE_BITS-1:0] value,
    output logic signed [rmth_pkg::SAMPLE_BITS-1:0] root,
    output logic [rmth_pkg::SIZE_BITS-1:0]          size,
    output logic                                   done
);
    import rmth_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_RD1,
        S_DN_RD2,
        S_DN_CMP,
        S_WRITE
    } state_t;

    logic signed [SAMPLE_BITS-1:0] mem [HEAP_DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_data;
    logic signed [SAMPLE_BITS-1:0] root_reg;
    logic [ADDR_BITS-1:0]          rd_addr;
    logic                          rd_en;
    logic                          wr_en;
    logic [ADDR_BITS-1:0]          wr_addr;
    logic signed [SAMPLE_BITS-1:0] wr_data;

    state_t                        state_reg;
    logic [SIZE_BITS-1:0]          size_reg;
    logic [SIZE_BITS-1:0]          idx_reg;
    logic [SIZE_BITS-1:0]          child_reg;
    logic signed [SAMPLE_BITS-1:0] val_reg;
    logic signed [SAMPLE_BITS-1:0] c1_reg;
    logic                          done_reg;

    logic [SIZE_BITS:0]            left_w;
    logic [SIZE_BITS-1:0]          parent_w;

    function automatic logic outranks(input logic mx,
                                      input logic signed [SAMPLE_BITS-1:0] a,
                                      input logic signed [SAMPLE_BITS-1:0] b);
        outranks = mx ? (a > b) : (a < b);
    endfunction

    assign left_w   = {idx_reg, 1'b0} + 1'b1;
    assign parent_w = (idx_reg - 1'b1) >> 1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            size_reg  <= '0;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
            child_reg <= '0;
            val_reg   <= '0;
            c1_reg    <= '0;
            root_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (wr_en && wr_addr == '0)
            begin
                root_reg <= wr_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (clear)
                    begin
                        size_reg <= '0;
                        done_reg <= 1'b1;
                    end
                    else if (push)
                    begin
                        val_reg  <= value;
                        idx_reg  <= size_reg;
                        size_reg <= size_reg + 1'b1;
                        state_reg <= (size_reg == '0) ? S_WRITE : S_UP_RD;
                    end
                    else if (pop)
                    begin
                        idx_reg  <= '0;
                        size_reg <= size_reg - 1'b1;
                        if (size_reg == SIZE_BITS'(1))
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_DN_LAST;
                        end
                    end
                end
                S_UP_RD:
                begin
                    state_reg <= S_UP_CMP;
                end
                S_UP_CMP:
                begin
                    if (outranks(is_max, val_reg, rd_data))
                    begin
                        idx_reg   <= parent_w;
                        state_reg <= (parent_w == '0) ? S_WRITE : S_UP_RD;
                    end
                    else
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_DN_LAST:
                begin
                    val_reg   <= rd_data;
                    state_reg <= S_DN_RD1;
                end
                S_DN_RD1:
                begin
                    if (left_w >= {1'b0, size_reg})
                    begin
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        child_reg <= left_w[SIZE_BITS-1:0];
                        state_reg <= S_DN_RD2;
                    end
                end
                S_DN_RD2:
                begin
                    c1_reg    <= rd_data;
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    if ({1'b0, child_reg} + 1'b1 < {1'b0, size_reg}
                        && outranks(is_max, rd_data, c1_reg))
                    begin
                        if (outranks(is_max, rd_data, val_reg))
                        begin
                            idx_reg   <= child_reg + 1'b1;
                            state_reg <= S_DN_RD1;
                        end
                        else
                        begin
                            state_reg <= S_WRITE;
                        end
                    end
                    else if (outranks(is_max, c1_reg, val_reg))
                    begin
                        idx_reg   <= child_reg;
                        state_reg <= S_DN_RD1;
                    end
                    else
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = idx_reg[ADDR_BITS-1:0];
        wr_data = val_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!clear && !push && pop)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ADDR_BITS'(size_reg - 1'b1);
                end
            end
            S_UP_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = parent_w[ADDR_BITS-1:0];
            end
            S_UP_CMP:
            begin
                if (outranks(is_max, val_reg, rd_data))
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                end
            end
            S_DN_RD1:
            begin
                rd_en   = 1'b1;
                rd_addr = left_w[ADDR_BITS-1:0];
            end
            S_DN_RD2:
            begin
                rd_en   = 1'b1;
                rd_addr = ADDR_BITS'(child_reg + 1'b1);
            end
            S_DN_CMP:
            begin
                if ({1'b0, child_reg} + 1'b1 < {1'b0, size_reg}
                    && outranks(is_max, rd_data, c1_reg))
                begin
                    if (outranks(is_max, rd_data, val_reg))
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data;
                    end
                end
                else if (outranks(is_max, c1_reg, val_reg))
                begin
                    wr_en   = 1'b1;
                    wr_data = c1_reg;
                end
            end
            S_WRITE:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign root = root_reg;
    assign size = size_reg;
    assign done = done_reg;

endmodule

// ===== rtl/rmth_datapath.sv =====
module rmth_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  rmth_pkg::rmth_cmd_t    cmd,
    input  rmth_pkg::rmth_in_t     in_item,
    output rmth_pkg::rmth_status_t status,
    output rmth_pkg::rmth_out_t    out_item
);
    import rmth_pkg::*;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] moved_reg;
    logic signed [MED_BITS-1:0]    median_reg;
    logic signed [SAMPLE_BITS-1:0] lo_root, up_root, push_val;
    logic [SIZE_BITS-1:0]          lo_size, up_size;
    logic                          lo_done, up_done;
    logic                          lo_push, up_push, lo_pop, up_pop, clr;
    logic [COUNT_BITS-1:0]         count;
    logic signed [MED_BITS-1:0]    s2;

    assign push_val = cmd.use_moved ? moved_reg : sample_reg;
    assign clr      = (cmd.op == DP_CLEAR);
    assign lo_push  = (cmd.op == DP_PUSH) && !cmd.heap_sel;
    assign up_push  = (cmd.op == DP_PUSH) && cmd.heap_sel;
    assign lo_pop   = (cmd.op == DP_POP) && !cmd.heap_sel;
    assign up_pop   = (cmd.op == DP_POP) && cmd.heap_sel;

    rmth_heap u_lower (
        .clk(clk), .rst_n(rst_n), .is_max(1'b1), .clear(clr),
        .push(lo_push), .pop(lo_pop), .value(push_val),
        .root(lo_root), .size(lo_size), .done(lo_done)
    );

    rmth_heap u_upper (
        .clk(clk), .rst_n(rst_n), .is_max(1'b0), .clear(clr),
        .push(up_push), .pop(up_pop), .value(push_val),
        .root(up_root), .size(up_size), .done(up_done)
    );

    assign count = COUNT_BITS'(lo_size) + COUNT_BITS'(up_size);
    assign s2    = {sample_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            median_reg <= '0;
            sample_reg <= '0;
            moved_reg  <= '0;
        end
        else
        begin
            case (cmd.op)
                DP_LOAD:
                begin
                    sample_reg <= in_item.sample;
                end
                DP_CLEAR:
                begin
                    median_reg <= '0;
                end
                DP_POP:
                begin
                    moved_reg <= cmd.heap_sel ? up_root : lo_root;
                end
                DP_MEDIAN:
                begin
                    if (lo_size > up_size)
                    begin
                        median_reg <= {lo_root, 1'b0};
                    end
                    else if (up_size > lo_size)
                    begin
                        median_reg <= {up_root, 1'b0};
                    end
                    else
                    begin
                        median_reg <= MED_BITS'(lo_root) + MED_BITS'(up_root);
                    end
                end
                default:
                begin
                    median_reg <= median_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        status.done        = lo_done | up_done;
        status.full        = (count >= COUNT_BITS'(2 * HEAP_DEPTH - 1));
        status.count_class = (count == '0) ? 2'd0 : (count == COUNT_BITS'(1)) ? 2'd1 : 2'd2;
        if (count == COUNT_BITS'(1))
        begin
            status.goes_upper = (s2 >= median_reg);
        end
        else if (s2 < median_reg)
        begin
            status.goes_upper = 1'b0;
        end
        else if (s2 > median_reg)
        begin
            status.goes_upper = 1'b1;
        end
        else
        begin
            status.goes_upper = (lo_size > up_size);
        end
        status.lower_heavy = ({1'b0, lo_size} > {1'b0, up_size} + 1'b1);
        status.upper_heavy = ({1'b0, up_size} > {1'b0, lo_size} + 1'b1);
    end

    assign out_item.median_doubled = median_reg;
    assign out_item.sample_count   = count[9:0];
    assign out_item.rejected       = 1'b0;

endmodule

// ===== rtl/rmth_ctrl.sv =====
module rmth_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  rmth_pkg::rmth_in_t     in_item,
    input  rmth_pkg::rmth_status_t status,
    output rmth_pkg::rmth_cmd_t    cmd,
    output logic                   busy,
    output logic                   strobe,
    output logic                   rejected
);
    import rmth_pkg::*;

    typedef enum logic [3:0] {
        C_IDLE,
        C_DECIDE,
        C_WAIT_PUSH,
        C_SECOND,
        C_WAIT_MOVE_POP,
        C_WAIT_MOVE_PUSH,
        C_PUSH_LOWER,
        C_BALANCE,
        C_MEDIAN,
        C_REPORT,
        C_WAIT_CLR
    } state_t;

    state_t    state_reg;
    rmth_cmd_t cmd_reg;
    logic      busy_reg, strobe_reg, rej_reg, final_reg, src_upper_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            cmd_reg       <= '{op: DP_NONE, heap_sel: 1'b0, use_moved: 1'b0};
            busy_reg      <= 1'b0;
            strobe_reg    <= 1'b0;
            rej_reg       <= 1'b0;
            final_reg     <= 1'b0;
            src_upper_reg <= 1'b0;
        end
        else
        begin
            cmd_reg    <= '{op: DP_NONE, heap_sel: 1'b0, use_moved: 1'b0};
            strobe_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    rej_reg <= 1'b0;
                    if (start)
                    begin
                        busy_reg <= 1'b1;
                        if (in_item.operation == OP_CLEAR)
                        begin
                            cmd_reg.op <= DP_CLEAR;
                            state_reg  <= C_WAIT_CLR;
                        end
                        else
                        begin
                            state_reg <= C_DECIDE;
                        end
                    end
                end
                C_WAIT_CLR:
                begin
                    state_reg <= C_REPORT;
                end
                C_DECIDE:
                begin
                    if (status.full)
                    begin
                        rej_reg   <= 1'b1;
                        state_reg <= C_REPORT;
                    end
                    else if (status.count_class == 2'd1 && !status.goes_upper)
                    begin
                        cmd_reg       <= '{op: DP_POP, heap_sel: 1'b0, use_moved: 1'b0};
                        src_upper_reg <= 1'b0;
                        final_reg     <= 1'b0;
                        state_reg     <= C_WAIT_MOVE_POP;
                    end
                    else
                    begin
                        cmd_reg <= '{op: DP_PUSH,
                                     heap_sel: (status.count_class != 2'd0) && status.goes_upper,
                                     use_moved: 1'b0};
                        state_reg <= C_WAIT_PUSH;
                    end
                end
                C_WAIT_PUSH:
                begin
                    if (status.done)
                    begin
                        state_reg <= C_BALANCE;
                    end
                end
                C_WAIT_MOVE_POP:
                begin
                    if (status.done)
                    begin
                        cmd_reg <= '{op: DP_PUSH, heap_sel: ~src_upper_reg,
                                     use_moved: 1'b1};
                        state_reg <= C_WAIT_MOVE_PUSH;
                    end
                end
                C_WAIT_MOVE_PUSH:
                begin
                    if (status.done)
                    begin
                        state_reg <= final_reg ? C_BALANCE : C_PUSH_LOWER;
                    end
                end
                C_PUSH_LOWER:
                begin
                    cmd_reg   <= '{op: DP_PUSH, heap_sel: 1'b0, use_moved: 1'b0};
                    final_reg <= 1'b1;
                    state_reg <= C_WAIT_PUSH;
                end
                C_BALANCE:
                begin
                    final_reg <= 1'b1;
                    if (status.lower_heavy || status.upper_heavy)
                    begin
                        cmd_reg <= '{op: DP_POP, heap_sel: status.upper_heavy,
                                     use_moved: 1'b0};
                        src_upper_reg <= status.upper_heavy;
                        state_reg     <= C_WAIT_MOVE_POP;
                    end
                    else
                    begin
                        cmd_reg.op <= DP_MEDIAN;
                        state_reg  <= C_MEDIAN;
                    end
                end
                C_MEDIAN:
                begin
                    state_reg <= C_REPORT;
                end
                C_REPORT:
                begin
                    strobe_reg <= 1'b1;
                    busy_reg   <= 1'b0;
                    state_reg  <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    // The sample is captured at the accepting edge, while it is still valid.
    always_comb
    begin
        cmd = cmd_reg;
        if (state_reg == C_IDLE && start)
        begin
            cmd.op = DP_LOAD;
        end
    end

    assign busy     = busy_reg;
    assign strobe   = strobe_reg;
    assign rejected = rej_reg;

endmodule

// ===== rtl/running_median_two_heaps.sv =====
// Running median of signed samples held in a lower max-heap and an upper
// min-heap, each in its own single-port memory. A transaction is accepted when
// start is high and busy is low; its result appears for one cycle with
// result_valid, and the receiver cannot stall it. A clear returns its result
// through the clear-wait and report states, a refused insert through the
// decide and report states. An insert returns its result after at most a
// sift-up, a sift-down and a second sift-up over eight heap levels, with one
// memory read per level going up and two going down. Busy drops in the cycle
// that carries the result, so the next transaction can be accepted then.
module running_median_two_heaps (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rmth_pkg::rmth_in_t  in_item,
    output logic                busy,
    output logic                result_valid,
    output rmth_pkg::rmth_out_t result
);
    import rmth_pkg::*;

    rmth_cmd_t    cmd;
    rmth_status_t status;
    rmth_out_t    dp_out;
    logic         rej;

    rmth_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item),
        .status(status), .cmd(cmd), .busy(busy), .strobe(result_valid),
        .rejected(rej)
    );

    rmth_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_item(in_item),
        .status(status), .out_item(dp_out)
    );

    always_comb
    begin
        result          = dp_out;
        result.rejected = rej;
    end

endmodule
